FILE: rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants of the double-ended queue
// Sizes, operation and status codes, controller/datapath bundles, ring math.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int DEPTH    = 32;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int DATA_W   = 32;
	localparam int OP_W     = 3;
	localparam int STATUS_W = 3;

	typedef logic [OP_W-1:0]            op_t;
	typedef logic [STATUS_W-1:0]        status_t;
	typedef logic signed [DATA_W-1:0]   data_t;
	typedef logic [IDX_W-1:0]           idx_t;
	typedef logic [CNT_W-1:0]           cnt_t;

	localparam op_t OP_PUSH_FRONT = 3'd0;
	localparam op_t OP_PUSH_REAR  = 3'd1;
	localparam op_t OP_POP_FRONT  = 3'd2;
	localparam op_t OP_POP_REAR   = 3'd3;
	localparam op_t OP_DUMP       = 3'd4;

	localparam status_t RES_OK    = 3'd0;
	localparam status_t RES_ELEM  = 3'd1;
	localparam status_t RES_EMPTY = 3'd2;
	localparam status_t RES_UNDER = 3'd3;
	localparam status_t RES_OVER  = 3'd4;
	localparam status_t RES_STOP  = 3'd5;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load;
		status_t status;
		logic    last;
		logic    push_front;
		logic    push_rear;
		logic    pop_front;
		logic    pop_rear;
		logic    set_stop;
		logic    rd_first;
		logic    rd_next;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic slot_free;
		logic stopped;
		logic empty;
		logic full;
		logic one_elem;
		logic idx_last;
	} dp_sts_t;

	// Modular add of two ring indexes, both below DEPTH.
	function automatic idx_t ring_add(idx_t a, idx_t b);
		logic [IDX_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= (IDX_W+1)'(DEPTH)) begin
			sum = sum - (IDX_W+1)'(DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage

FILE: rtl/deq_if.sv
// ----------------------------------------------------------------------------
// deq_if: request and response channels of the double-ended queue
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface deq_req_if import deq_pkg::*; ();
	logic  valid;
	logic  ready;
	op_t   operation;
	data_t value;

	modport source (output valid, output operation, output value, input ready);
	modport sink   (input valid, input operation, input value, output ready);
endinterface

interface deq_rsp_if import deq_pkg::*; ();
	logic    valid;
	logic    ready;
	status_t status;
	data_t   element;
	logic    last;

	modport source (output valid, output status, output element, output last, input ready);
	modport sink   (input valid, input status, input element, input last, output ready);
endinterface

FILE: rtl/deq_dpath.sv
// ----------------------------------------------------------------------------
// deq_dpath: storage and result register of the double-ended queue
// Ring store, head index, count, stopped flag, dump index and output beat.
// ----------------------------------------------------------------------------
module deq_dpath import deq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  dp_cmd_t cmd,
	output dp_sts_t sts,
	input  data_t   value,
	input  logic    out_ready,
	output logic    out_valid,
	output status_t out_status,
	output data_t   out_element,
	output logic    out_last
);

	data_t   mem [DEPTH];
	idx_t    head_q;
	cnt_t    count_q;
	logic    stopped_q;
	idx_t    idx_q;
	logic    valid_q;
	status_t status_q;
	logic    last_q;
	data_t   rd_data_q;

	idx_t head_dec;
	idx_t wr_addr;
	idx_t rd_addr;
	logic wr_en;
	logic rd_en;

	assign head_dec = (head_q == '0) ? idx_t'(DEPTH - 1) : head_q - idx_t'(1);
	assign wr_en    = cmd.push_front || cmd.push_rear;
	assign wr_addr  = cmd.push_front ? head_dec : ring_add(head_q, count_q[IDX_W-1:0]);
	assign rd_en    = cmd.rd_first || cmd.rd_next;
	assign rd_addr  = ring_add(head_q, cmd.rd_first ? idx_t'(0) : idx_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= value;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			count_q   <= '0;
			stopped_q <= 1'b0;
			idx_q     <= '0;
			valid_q   <= 1'b0;
		end else begin
			if (cmd.push_front) begin
				head_q <= head_dec;
			end else if (cmd.pop_front) begin
				head_q <= ring_add(head_q, idx_t'(1));
			end
			if (wr_en) begin
				count_q <= count_q + cnt_t'(1);
			end else if (cmd.pop_front || cmd.pop_rear) begin
				count_q <= count_q - cnt_t'(1);
			end
			if (cmd.set_stop) begin
				stopped_q <= 1'b1;
			end
			if (cmd.rd_first) begin
				idx_q <= idx_t'(1);
			end else if (cmd.rd_next) begin
				idx_q <= idx_q + idx_t'(1);
			end
			if (cmd.load) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status_q <= cmd.status;
			last_q   <= cmd.last;
		end
	end

	assign sts.slot_free = !valid_q || out_ready;
	assign sts.stopped   = stopped_q;
	assign sts.empty     = (count_q == '0);
	assign sts.full      = (count_q == cnt_t'(DEPTH));
	assign sts.one_elem  = (count_q == cnt_t'(1));
	assign sts.idx_last  = ((cnt_t'(idx_q) + cnt_t'(1)) == count_q);

	assign out_valid   = valid_q;
	assign out_status  = status_q;
	assign out_last    = last_q;
	assign out_element = (status_q == RES_ELEM) ? rd_data_q : '0;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cnt_t'(DEPTH))
		else $error("element count exceeds the ring depth");

	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> stopped_q)
		else $error("stopped flag cleared without reset");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> sts.slot_free)
		else $error("result loaded over a beat still waiting");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push_front || cmd.push_rear) |-> (!sts.full && !stopped_q))
		else $error("push issued on a full or stopped queue");

endmodule

FILE: rtl/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl: controller of the double-ended queue
// Decodes each request and sequences the dump walk over stored entries.
// ----------------------------------------------------------------------------
module deq_ctrl import deq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  op_t     operation,
	output logic    in_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_DUMP = 1'b1;

	logic state_q;
	logic state_d;

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		state_d  = state_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = sts.slot_free;
				if (in_valid && sts.slot_free) begin
					cmd.load = 1'b1;
					cmd.last = 1'b1;
					if (sts.stopped) begin
						cmd.status = RES_STOP;
					end else begin
						unique case (operation) inside
							OP_PUSH_FRONT, OP_PUSH_REAR: begin
								if (sts.full) begin
									cmd.status = RES_OVER;
								end else begin
									cmd.status     = RES_OK;
									cmd.push_front = (operation == OP_PUSH_FRONT);
									cmd.push_rear  = (operation == OP_PUSH_REAR);
								end
							end
							OP_POP_FRONT, OP_POP_REAR: begin
								if (sts.empty) begin
									cmd.status   = RES_UNDER;
									cmd.set_stop = 1'b1;
								end else begin
									cmd.status    = RES_OK;
									cmd.pop_front = (operation == OP_POP_FRONT);
									cmd.pop_rear  = (operation == OP_POP_REAR);
								end
							end
							default: begin
								// Dump, and the unused codes that behave as one.
								if (sts.empty) begin
									cmd.status = RES_EMPTY;
								end else begin
									cmd.status   = RES_ELEM;
									cmd.rd_first = 1'b1;
									cmd.last     = sts.one_elem;
									if (!sts.one_elem) begin
										state_d = S_DUMP;
									end
								end
							end
						endcase
					end
				end
			end
			S_DUMP: begin
				if (sts.slot_free) begin
					cmd.load    = 1'b1;
					cmd.status  = RES_ELEM;
					cmd.rd_next = 1'b1;
					cmd.last    = sts.idx_last;
					if (sts.idx_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_no_accept_in_dump: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP) |-> !in_ready)
		else $error("request taken during a dump walk");

	a_dump_reads: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DUMP) && sts.slot_free) |-> (cmd.load && cmd.rd_next))
		else $error("dump walk stalled with a free output slot");

	a_dump_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rd_next && cmd.last) |=> (state_q == S_IDLE))
		else $error("dump walk did not end after its last beat");

endmodule

FILE: rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue: deque of signed 32-bit values in a ring store
// Latency: a request's first response beat is valid the cycle after it is taken.
// Beats: push, pop and stopped requests give one beat each; a dump of N
// entries gives N beats, one ring store read per cycle unless rsp stalls.
// Reset: arst_n clears head, count, stopped flag and the controller at once;
// the ring store holds no reset and each entry is read only after a write.
// ----------------------------------------------------------------------------
module double_ended_queue import deq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	deq_req_if.sink  req,
	deq_rsp_if.source rsp
);

	// The controller decodes each request beat and drives the datapath with a
	// command bundle. The datapath owns the ring store, the head index, the
	// element count, the sticky stopped flag and the single response register.
	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    req_ready;

	// A new request is taken only while the response register is empty or is
	// being drained in the same cycle, and never during a dump walk.
	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.operation (req.operation),
		.in_ready  (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// During a dump the datapath reads one entry per cycle, front to rear, unless
	// rsp stalls, into the response register; the last read carries the last mark.
	deq_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.value       (req.value),
		.out_ready   (rsp.ready),
		.out_valid   (rsp.valid),
		.out_status  (rsp.status),
		.out_element (rsp.element),
		.out_last    (rsp.last)
	);

	assign req.ready = req_ready;

endmodule

FILE: tb/deq_response_checker.sv
// ----------------------------------------------------------------------------
// deq_response_checker: response prediction and comparison for the deque
// Watches both channels, keeps a shadow of the queue contents, queues the
// beats that each accepted request should produce and compares them in order.
// ----------------------------------------------------------------------------
module deq_response_checker import deq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	deq_req_if         req,
	deq_rsp_if         rsp,
	output int         mismatches,
	output int         owed,
	output int         beats_seen,
	output logic [7:0] statuses_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		status_t status;
		data_t   element;
		logic    last;
	} rsp_beat_t;

	rsp_beat_t owed_beats[$];

	data_t shadow_store [DEPTH];
	int    shadow_head;
	int    shadow_count;
	bit    shadow_stopped;

	function automatic void owe_beat(status_t status, data_t element, logic last);
		rsp_beat_t b;
		b.status  = status;
		b.element = element;
		b.last    = last;
		owed_beats.push_back(b);
	endfunction

	// Applies one request to the shadow queue and records the beats it owes.
	function automatic void apply_request(op_t op, data_t value);
		if (shadow_stopped) begin
			owe_beat(RES_STOP, '0, 1'b1);
			return;
		end
		case (op)
			OP_PUSH_FRONT, OP_PUSH_REAR: begin
				if (shadow_count >= DEPTH) begin
					owe_beat(RES_OVER, '0, 1'b1);
				end else begin
					if (op == OP_PUSH_FRONT) begin
						shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
						shadow_store[shadow_head] = value;
					end else begin
						shadow_store[(shadow_head + shadow_count) % DEPTH] = value;
					end
					shadow_count++;
					owe_beat(RES_OK, '0, 1'b1);
				end
			end
			OP_POP_FRONT, OP_POP_REAR: begin
				if (shadow_count == 0) begin
					shadow_stopped = 1'b1;
					owe_beat(RES_UNDER, '0, 1'b1);
				end else begin
					if (op == OP_POP_FRONT) begin
						shadow_head = (shadow_head + 1) % DEPTH;
					end
					shadow_count--;
					owe_beat(RES_OK, '0, 1'b1);
				end
			end
			default: begin
				// The dump and every spare code walk the queue front to rear.
				if (shadow_count == 0) begin
					owe_beat(RES_EMPTY, '0, 1'b1);
				end else begin
					for (int i = 0; i < shadow_count; i++) begin
						owe_beat(RES_ELEM, shadow_store[(shadow_head + i) % DEPTH],
							i == shadow_count - 1);
					end
				end
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_beat_t want;
		if (!arst_n) begin
			owed_beats.delete();
			shadow_head    = 0;
			shadow_count   = 0;
			shadow_stopped = 1'b0;
			mismatches     = 0;
			owed           = 0;
			beats_seen     = 0;
			statuses_seen  = '0;
		end else begin
			if (req.valid && req.ready) begin
				apply_request(req.operation, req.value);
			end
			if (rsp.valid && rsp.ready) begin
				beats_seen++;
				statuses_seen[rsp.status] = 1'b1;
				if (owed_beats.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected beat, status %0d element %0d last %0d",
						$time, rsp.status, rsp.element, rsp.last);
				end else begin
					want = owed_beats.pop_front();
					if (want.status !== rsp.status || want.element !== rsp.element ||
						want.last !== rsp.last) begin
						mismatches++;
						$display("%0t: beat mismatch, expected status %0d element %0d last %0d",
							$time, want.status, want.element, want.last);
						$display("%0t:                  got status %0d element %0d last %0d",
							$time, rsp.status, rsp.element, rsp.last);
					end
				end
			end
			owed = owed_beats.size();
		end
	end

endmodule

FILE: tb/tb_double_ended_queue.sv
// ----------------------------------------------------------------------------
// tb_double_ended_queue: self-checking bench of the double-ended queue
// Drives directed and random request sequences with random idle gaps on both
// channels, a long output hold-off and a fill to overflow, then ends with an
// underflow and stopped traffic; a separate checker predicts every beat.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;
	timeunit 1ns;
	timeprecision 1ps;

	import deq_pkg::*;

	// Codes 5 to 7 have no name in the package; the block treats them as a dump.
	localparam op_t OP_SPARE_LO  = 3'd5;
	localparam op_t OP_SPARE_MID = 3'd6;
	localparam op_t OP_SPARE_HI  = 3'd7;

	localparam int RANDOM_REQUESTS = 50;
	localparam int HOLD_CYCLES     = 150;
	localparam int SETTLE_CYCLES   = 48;

	logic clk;
	logic arst_n;

	deq_req_if req ();
	deq_rsp_if rsp ();

	int         mismatches;
	int         owed;
	int         beats_seen;
	logic [7:0] statuses_seen;

	// Occupancy as seen from the request side. It lets the stimulus avoid
	// popping an empty queue until the very end, since an underflow stops the
	// block for good and reset is applied only once.
	int fill_level;
	int requests_sent;

	// Steady phases switch idling off on one or both sides.
	bit sender_steady;
	bit receiver_steady;

	// Set by the stimulus to ask the receiver for its long hold-off.
	bit hold_pending;

	double_ended_queue u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	deq_response_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.rsp           (rsp),
		.mismatches    (mismatches),
		.owed          (owed),
		.beats_seen    (beats_seen),
		.statuses_seen (statuses_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Gap lengths: mostly none, often a few cycles, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) begin
			return 0;
		end else if (roll < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(6, 24);
	endfunction

	// Values lean on the sign boundary and the all-zero and all-one patterns,
	// the rest are fully random so that every bit toggles.
	function automatic data_t pick_value();
		case ($urandom_range(0, 19))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return 32'h0000_0000;
			3:       return 32'hFFFF_FFFF;
			default: return data_t'($urandom);
		endcase
	endfunction

	function automatic op_t pick_push();
		return ($urandom_range(0, 1) != 0) ? OP_PUSH_REAR : OP_PUSH_FRONT;
	endfunction

	function automatic op_t pick_pop();
		return ($urandom_range(0, 1) != 0) ? OP_POP_REAR : OP_POP_FRONT;
	endfunction

	// Offers one request and returns once the beat has been taken. The valid
	// stays high into the next request unless a gap is drawn, so there is only
	// ever one assignment to it per clock edge.
	task automatic send_request(op_t op, data_t value);
		int gap;
		req.valid     <= 1'b1;
		req.operation <= op;
		req.value     <= value;
		do @(posedge clk); while (!req.ready);
		requests_sent++;
		case (op)
			OP_PUSH_FRONT, OP_PUSH_REAR: begin
				if (fill_level < DEPTH) begin
					fill_level++;
				end
			end
			OP_POP_FRONT, OP_POP_REAR: begin
				if (fill_level > 0) begin
					fill_level--;
				end
			end
			default: ;
		endcase
		gap = sender_steady ? 0 : pick_gap();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Response side. The ready follows its own schedule: random stalls, the
	// long hold-off on request, and no stalls at all in steady phases.
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left  = 0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				rsp.ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				rsp.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp.ready <= 1'b1;
				if (!receiver_steady && $urandom_range(0, 2) == 0) begin
					stall_left = pick_gap();
				end
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		int  roll;
		op_t op;

		req.valid       <= 1'b0;
		req.operation   <= OP_PUSH_FRONT;
		req.value       <= '0;
		arst_n          <= 1'b0;
		fill_level      = 0;
		requests_sent   = 0;
		sender_steady   = 1'b0;
		receiver_steady = 1'b0;
		hold_pending    = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty dump, extreme values at both ends, every spare
		// code acting as a dump, pops from both ends down to empty, and a
		// front push that wraps the head below slot zero.
		send_request(OP_DUMP, '0);
		send_request(OP_PUSH_REAR, 32'h7FFF_FFFF);
		send_request(OP_PUSH_FRONT, 32'h8000_0000);
		send_request(OP_PUSH_REAR, 32'h0000_0000);
		send_request(OP_PUSH_FRONT, 32'hFFFF_FFFF);
		send_request(OP_DUMP, 32'h1234_5678);
		send_request(OP_SPARE_LO, '0);
		send_request(OP_POP_FRONT, 32'hFFFF_FFFF);
		send_request(OP_POP_REAR, '0);
		send_request(OP_SPARE_MID, '0);
		send_request(OP_PUSH_FRONT, 32'h5555_5555);
		send_request(OP_PUSH_REAR, 32'hAAAA_AAAA);
		send_request(OP_SPARE_HI, 32'hFFFF_FFFF);
		send_request(OP_POP_REAR, '0);
		send_request(OP_POP_FRONT, '0);
		send_request(OP_POP_FRONT, '0);
		send_request(OP_POP_REAR, '0);
		send_request(OP_DUMP, '0);
		send_request(OP_PUSH_FRONT, 32'h0000_0001);
		send_request(OP_POP_REAR, '0);
		send_request(OP_PUSH_REAR, 32'h0000_0002);
		send_request(OP_POP_FRONT, '0);

		// Random part: well-formed traffic that never pops an empty queue.
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n == 20) begin
				// Fill to the brim while the receiver holds off, so the block
				// backs up and stalls its input. Then overflow it and dump the
				// full ring, which gives the longest run of beats.
				hold_pending = 1'b1;
				while (fill_level < DEPTH) begin
					send_request(pick_push(), pick_value());
				end
				repeat (3) send_request(pick_push(), pick_value());
				send_request(OP_DUMP, pick_value());
			end
			sender_steady   = (n >= 30 && n < 42);
			receiver_steady = (n >= 30 && n < 40);

			roll = $urandom_range(0, 99);
			if (roll < 42) begin
				op = pick_push();
			end else if (roll < 78 && fill_level > 0) begin
				op = pick_pop();
			end else if (roll < 92) begin
				op = OP_DUMP;
			end else begin
				case ($urandom_range(0, 2))
					0:       op = OP_SPARE_LO;
					1:       op = OP_SPARE_MID;
					default: op = OP_SPARE_HI;
				endcase
			end
			send_request(op, pick_value());
		end
		sender_steady   = 1'b0;
		receiver_steady = 1'b0;

		// Drain, underflow once, then show that pushes, pops, a dump and a spare
		// code only get a stopped answer afterwards.
		while (fill_level > 0) begin
			send_request(pick_pop(), pick_value());
		end
		send_request(OP_DUMP, pick_value());
		send_request(OP_POP_FRONT, pick_value());
		send_request(OP_PUSH_FRONT, pick_value());
		send_request(OP_PUSH_REAR, pick_value());
		send_request(OP_POP_REAR, pick_value());
		send_request(OP_DUMP, pick_value());
		send_request(OP_SPARE_HI, pick_value());
		req.valid <= 1'b0;

		// Wait for every owed beat, then a little longer to catch strays.
		@(posedge clk);
		while (owed != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d requests and checked %0d response beats.",
			requests_sent, beats_seen);
		$display("Status codes seen, stopped down to ok: %b.", statuses_seen[5:0]);
		if (mismatches == 0 && owed == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Watchdog far beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("Timed out with %0d beats still owed.", owed);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: files.f
rtl/deq_pkg.sv
rtl/deq_if.sv
rtl/deq_dpath.sv
rtl/deq_ctrl.sv
rtl/double_ended_queue.sv
tb/deq_response_checker.sv
tb/tb_double_ended_queue.sv
